// ===== src/elc_pkg.sv =====
// Shared types, constants and field widths for the elevator car controller.
package elc_pkg;

    // Building size and fixed field widths
    localparam int FLOORS     = 8;
    localparam int FLOOR_W    = 3;
    localparam int TYPE_W     = 3;
    localparam int DELTA_W    = 16;
    localparam int SPEED_W    = 17;
    localparam int TIME_W     = 16;
    localparam int POS_W      = 19;
    localparam int DOOR_W     = 17;
    localparam int GOAL_W     = 4;
    localparam int PROD_W     = SPEED_W + DELTA_W;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    localparam logic [GOAL_W-1:0] FLOOR_LIMIT = GOAL_W'(FLOORS);
    localparam logic [GOAL_W-1:0] GOAL_NONE   = '1;

    // Q16 constants
    localparam logic [DOOR_W-1:0] DOOR_FULL      = 17'd65536;
    localparam logic [DOOR_W-1:0] DOOR_OPEN_MARK = 17'd655;
    localparam logic [POS_W-1:0]  POS_RESET      = 19'd65536;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET   = 3'd1;

    // Configuration reset values
    localparam logic [SPEED_W-1:0] CAR_SPEED_RESET  = 17'd66;
    localparam logic [SPEED_W-1:0] DOOR_RATE_RESET  = 17'd131;
    localparam logic [TIME_W-1:0]  OPEN_TIME_RESET  = 16'd3000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAR_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME  = 2'd2;

    // Item kinds
    localparam logic [TYPE_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_FLOOR  = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_CALL   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_OPEN   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_CLOSE  = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_STOP   = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_VENT   = 3'd6;

    typedef struct packed {
        logic [SPEED_W-1:0] car_speed;
        logic [SPEED_W-1:0] door_rate;
        logic [TIME_W-1:0]  open_hold_ms;
    } t_cfg;

    // Registered item with its speed-times-delta products
    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [FLOOR_W-1:0] floor;
        logic [DELTA_W-1:0] delta_ms;
        logic [PROD_W-1:0]  car_step;
        logic [PROD_W-1:0]  door_step;
    } t_item;

    typedef struct packed {
        logic [FLOOR_W-1:0] current_floor;
        logic [FLOOR_W-1:0] target_floor;
        logic               is_moving;
        logic               is_stopped;
        logic [POS_W-1:0]   car_position;
        logic [DOOR_W-1:0]  door_amount;
        logic               doors_open;
        logic [FLOORS-1:0]  pending_requests;
        logic               ventilation_on;
        logic               ventilation_lamp;
    } t_result;

endpackage

// ===== src/elc_cfg.sv =====
// Configuration registers written through the config channel.
module elc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [elc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [elc_pkg::SPEED_W-1:0]    i_cfg_data,
    output elc_pkg::t_cfg                  o_cfg
);

    elc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Store a register on each transfer; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.car_speed    <= elc_pkg::CAR_SPEED_RESET;
            r_cfg.door_rate    <= elc_pkg::DOOR_RATE_RESET;
            r_cfg.open_hold_ms <= elc_pkg::OPEN_TIME_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == elc_pkg::CFG_CAR_SPEED) begin
                r_cfg.car_speed <= i_cfg_data;
            end else if (i_cfg_index == elc_pkg::CFG_DOOR_RATE) begin
                r_cfg.door_rate <= i_cfg_data;
            end else if (i_cfg_index == elc_pkg::CFG_OPEN_TIME) begin
                r_cfg.open_hold_ms <= i_cfg_data[elc_pkg::TIME_W-1:0];
            end
        end
    end

endmodule

// ===== src/elc_in_stage.sv =====
// Input register: captures an item and forms the travel products.
module elc_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [elc_pkg::TYPE_W-1:0]    i_req_type,
    input  logic [elc_pkg::FLOOR_W-1:0]   i_floor,
    input  logic [elc_pkg::DELTA_W-1:0]   i_delta_ms,
    input  elc_pkg::t_cfg                 i_cfg,
    input  logic                          i_out_free,
    output logic                          o_advance,
    output elc_pkg::t_item                o_item
);

    logic           r_valid;
    elc_pkg::t_item r_item;
    elc_pkg::t_item n_item;

    // Item leaves when the result register can take it
    assign o_advance = r_valid && i_out_free;
    assign o_ready   = !r_valid || o_advance;
    assign o_item    = r_item;

    // Form the speed-times-delta products ahead of the state update
    always_comb begin
        n_item.req_type  = i_req_type;
        n_item.floor     = i_floor;
        n_item.delta_ms  = i_delta_ms;
        n_item.car_step  = elc_pkg::PROD_W'(i_cfg.car_speed) *
                           elc_pkg::PROD_W'(i_delta_ms);
        n_item.door_step = elc_pkg::PROD_W'(i_cfg.door_rate) *
                           elc_pkg::PROD_W'(i_delta_ms);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== src/elc_core.sv =====
// Controller state and its single-pass next-state logic.
module elc_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  elc_pkg::t_item         i_item,
    input  elc_pkg::t_cfg          i_cfg,
    output elc_pkg::t_result       o_result
);

    // State
    logic [elc_pkg::FLOOR_W-1:0] r_floor_now,  n_floor_now;
    logic [elc_pkg::FLOOR_W-1:0] r_floor_goal, n_floor_goal;
    logic [elc_pkg::GOAL_W-1:0]  r_first_goal, n_first_goal;
    logic [elc_pkg::POS_W-1:0]   r_position,   n_position;
    logic [elc_pkg::DOOR_W-1:0]  r_door_level, n_door_level;
    logic [elc_pkg::TIME_W-1:0]  r_countdown,  n_countdown;
    logic [elc_pkg::FLOORS-1:0]  r_req_map,    n_req_map;
    logic r_moving,   n_moving;
    logic r_stopped,  n_stopped;
    logic r_dooropen, n_dooropen;
    logic r_waiting,  n_waiting;
    logic r_vent,     n_vent;
    logic r_lamp,     n_lamp;

    // Working values
    logic                        here;
    logic                        floor_ok;
    logic                        add_req;
    logic                        add_light;
    logic                        pending_any;
    logic [elc_pkg::FLOOR_W-1:0] pending_low;
    logic [elc_pkg::PROD_W-1:0]  door_sum;
    logic [elc_pkg::POS_W-1:0]   target_pos;
    logic [elc_pkg::POS_W-1:0]   travel_left;

    assign here     = (i_item.floor == r_floor_now) && !r_moving;
    assign floor_ok = {1'b0, i_item.floor} < elc_pkg::FLOOR_LIMIT;

    // Find the lowest pending floor
    always_comb begin
        pending_any = 1'b0;
        pending_low = '0;
        for (int i = elc_pkg::FLOORS - 1; i >= 0; i--) begin
            if (r_req_map[i]) begin
                pending_any = 1'b1;
                pending_low = elc_pkg::FLOOR_W'(i);
            end
        end
    end

    // Apply one item to the state
    always_comb begin
        n_floor_now  = r_floor_now;
        n_floor_goal = r_floor_goal;
        n_first_goal = r_first_goal;
        n_position   = r_position;
        n_door_level = r_door_level;
        n_countdown  = r_countdown;
        n_req_map    = r_req_map;
        n_moving     = r_moving;
        n_stopped    = r_stopped;
        n_dooropen   = r_dooropen;
        n_waiting    = r_waiting;
        n_vent       = r_vent;
        n_lamp       = r_lamp;
        add_req      = 1'b0;
        add_light    = 1'b0;
        door_sum     = elc_pkg::PROD_W'(r_door_level) + i_item.door_step;
        target_pos   = {n_floor_goal, 16'd0};
        travel_left  = '0;

        unique case (i_item.req_type)
            elc_pkg::REQ_TICK: begin
                // Door phase
                if (r_dooropen) begin
                    if (elc_pkg::TIME_W'(i_item.delta_ms) >= r_countdown) begin
                        n_countdown = '0;
                    end else begin
                        n_countdown = r_countdown - i_item.delta_ms;
                    end
                    if (r_door_level < elc_pkg::DOOR_FULL) begin
                        if (door_sum > elc_pkg::PROD_W'(elc_pkg::DOOR_FULL)) begin
                            n_door_level = elc_pkg::DOOR_FULL;
                        end else begin
                            n_door_level = door_sum[elc_pkg::DOOR_W-1:0];
                        end
                    end
                    if (n_countdown == '0) begin
                        n_dooropen = 1'b0;
                    end
                end else begin
                    if (r_door_level != '0) begin
                        if (i_item.door_step >= elc_pkg::PROD_W'(r_door_level)) begin
                            n_door_level = '0;
                        end else begin
                            n_door_level = r_door_level -
                                           i_item.door_step[elc_pkg::DOOR_W-1:0];
                        end
                    end
                    // Doors shut: head for the lowest pending floor
                    if (n_door_level == '0 && r_waiting) begin
                        n_waiting    = 1'b0;
                        n_floor_goal = '0;
                        if (pending_any) begin
                            n_floor_goal = pending_low;
                            n_moving     = 1'b1;
                        end
                    end
                end

                // Travel phase, never past the target
                target_pos  = {n_floor_goal, 16'd0};
                travel_left = (target_pos >= r_position) ? target_pos - r_position
                                                         : r_position - target_pos;
                if (n_moving && !r_stopped) begin
                    if (elc_pkg::PROD_W'(travel_left) <= i_item.car_step) begin
                        n_position  = target_pos;
                        n_floor_now = n_floor_goal;
                        n_moving    = 1'b0;
                        n_req_map[n_floor_goal] = 1'b0;
                        n_dooropen  = 1'b1;
                        n_waiting   = 1'b1;
                        n_countdown = i_cfg.open_hold_ms;
                        if (r_lamp && {1'b0, n_floor_goal} == r_first_goal) begin
                            n_lamp = 1'b0;
                        end
                    end else if (target_pos > r_position) begin
                        n_position = r_position +
                                     i_item.car_step[elc_pkg::POS_W-1:0];
                    end else begin
                        n_position = r_position -
                                     i_item.car_step[elc_pkg::POS_W-1:0];
                    end
                end
            end
            elc_pkg::REQ_FLOOR: begin
                add_req   = floor_ok && !here;
                add_light = 1'b1;
            end
            elc_pkg::REQ_CALL: begin
                if (floor_ok) begin
                    if (here) begin
                        if (!r_dooropen) begin
                            n_dooropen  = 1'b1;
                            n_waiting   = 1'b1;
                            n_countdown = i_cfg.open_hold_ms;
                        end
                    end else begin
                        add_req = 1'b1;
                    end
                end
            end
            elc_pkg::REQ_OPEN: begin
                if (!r_moving) begin
                    n_dooropen  = 1'b1;
                    n_waiting   = 1'b1;
                    n_countdown = i_cfg.open_hold_ms;
                end
            end
            elc_pkg::REQ_CLOSE: begin
                if (r_dooropen || r_door_level != '0) begin
                    n_dooropen  = 1'b0;
                    n_countdown = '0;
                end
            end
            elc_pkg::REQ_STOP: begin
                n_stopped = !r_stopped;
            end
            elc_pkg::REQ_VENT: begin
                n_vent = !r_vent;
                if (!r_vent && r_moving) begin
                    n_lamp = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Record a floor request; start now if the doors are shut, else start closing them
        if (add_req) begin
            n_req_map[i_item.floor] = 1'b1;
            if (!r_moving) begin
                if (r_door_level == '0) begin
                    n_floor_goal = i_item.floor;
                    n_first_goal = {1'b0, i_item.floor};
                    n_moving     = 1'b1;
                    n_waiting    = 1'b0;
                    if (add_light && r_vent) begin
                        n_lamp = 1'b1;
                    end
                end else begin
                    n_dooropen  = 1'b0;
                    n_countdown = '0;
                    n_waiting   = 1'b1;
                end
            end
        end
    end

    // Status that goes with this item
    always_comb begin
        o_result.current_floor    = n_floor_now;
        o_result.target_floor     = n_floor_goal;
        o_result.is_moving        = n_moving;
        o_result.is_stopped       = n_stopped;
        o_result.car_position     = n_position;
        o_result.door_amount      = n_door_level;
        o_result.doors_open       = n_door_level > elc_pkg::DOOR_OPEN_MARK;
        o_result.pending_requests = n_req_map;
        o_result.ventilation_on   = n_vent;
        o_result.ventilation_lamp = n_lamp;
    end

    // Commit the state when the item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_now  <= elc_pkg::FLOOR_RESET;
            r_floor_goal <= '0;
            r_first_goal <= elc_pkg::GOAL_NONE;
            r_position   <= elc_pkg::POS_RESET;
            r_door_level <= '0;
            r_countdown  <= '0;
            r_req_map    <= '0;
            r_moving     <= 1'b0;
            r_stopped    <= 1'b0;
            r_dooropen   <= 1'b0;
            r_waiting    <= 1'b0;
            r_vent       <= 1'b0;
            r_lamp       <= 1'b0;
        end else if (i_advance) begin
            r_floor_now  <= n_floor_now;
            r_floor_goal <= n_floor_goal;
            r_first_goal <= n_first_goal;
            r_position   <= n_position;
            r_door_level <= n_door_level;
            r_countdown  <= n_countdown;
            r_req_map    <= n_req_map;
            r_moving     <= n_moving;
            r_stopped    <= n_stopped;
            r_dooropen   <= n_dooropen;
            r_waiting    <= n_waiting;
            r_vent       <= n_vent;
            r_lamp       <= n_lamp;
        end
    end

endmodule

// ===== src/elc_out_stage.sv =====
// Result register: holds a status item until the downstream side takes it.
module elc_out_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  elc_pkg::t_result                  i_result,
    output logic                              o_free,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [elc_pkg::OUT_DATA_W-1:0]    o_data
);

    logic             r_valid;
    elc_pkg::t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;

    // Pack fields from the lowest bit up, pad the top bit
    assign o_data = {1'b0,
                     r_result.ventilation_lamp,
                     r_result.ventilation_on,
                     r_result.pending_requests,
                     r_result.doors_open,
                     r_result.door_amount,
                     r_result.car_position,
                     r_result.is_stopped,
                     r_result.is_moving,
                     r_result.target_floor,
                     r_result.current_floor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Load a new result on each advance
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== src/elevator_car_controller.sv =====
// Top level of the single-car elevator controller.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser req_type, tdata floor, delta_ms
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata status fields
//  cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One item per cycle while the result register is free: an item sits in the input
// register, where the speed-times-delta products are already formed, then the state
// update and the status it reports take one pass into the result register.
// Synchronous active-low reset clears both stage valids and the controller
// state; config returns to 66 / 131 / 3000. A stalled result register holds the
// input register, which still takes an item while it is empty.
module elevator_car_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // s_axis_tdata: floor [2:0], delta_ms [18:3], zero [23:19]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [elc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // s_axis_tuser: req_type [2:0]
    input  logic [elc_pkg::TYPE_W-1:0]        s_axis_tuser,
    // m_axis_tdata: current_floor [2:0], target_floor [5:3], is_moving [6],
    // is_stopped [7], car_position [26:8], door_amount [43:27],
    // doors_open [44], pending_requests [52:45], ventilation_on [53],
    // ventilation_lamp [54], zero [55]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [elc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [elc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [elc_pkg::SPEED_W-1:0]       i_cfg_data
);

    elc_pkg::t_cfg    cfg;
    elc_pkg::t_item   item;
    elc_pkg::t_result result;
    logic             advance;
    logic             out_free;

    elc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    elc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req_type (s_axis_tuser),
        .i_floor    (s_axis_tdata[elc_pkg::FLOOR_W-1:0]),
        .i_delta_ms (s_axis_tdata[elc_pkg::FLOOR_W +: elc_pkg::DELTA_W]),
        .i_cfg      (cfg),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_item     (item)
    );

    elc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (item),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    elc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule

// ===== dv/elevator_car_controller_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the elevator car controller with a status predictor.
module elevator_car_controller_tb;

    // Codes the package leaves unnamed
    localparam logic [elc_pkg::TYPE_W-1:0]    REQ_UNUSED = 3'd7;
    localparam logic [elc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int          CLK_HALF        = 5;
    localparam int          RESET_CYCLES    = 5;
    localparam int          WATCHDOG_LIMIT  = 3000;
    localparam int          SETTLE_CYCLES   = 6;
    localparam int          PHASES          = 6;
    localparam int          ITEMS_PER_PHASE = 192;
    localparam int          HOLD_CYCLES     = 64;
    localparam int          PAUSE_AT        = 600;
    localparam int          HOLD_AT         = 900;
    localparam longint      FLOOR_STEP      = 65536;

    // Register settings per phase; phase 0 runs on the reset values
    localparam logic [elc_pkg::SPEED_W-1:0] CAR_SPEEDS [PHASES] =
        '{17'd66, 17'd65536, 17'd1, 17'd0, 17'd660, 17'd13107};
    localparam logic [elc_pkg::SPEED_W-1:0] DOOR_RATES [PHASES] =
        '{17'd131, 17'd65536, 17'd1, 17'd0, 17'd1310, 17'd6553};
    localparam logic [elc_pkg::TIME_W-1:0]  OPEN_TIMES [PHASES] =
        '{16'd3000, 16'd0, 16'd65535, 16'd100, 16'd500, 16'd1};

    // Status values expected from the reset state and after a single stop or vent toggle
    localparam elc_pkg::t_result IDLE_STATUS   = '{3'd1, 3'd0, 1'b0, 1'b0,
                                                   elc_pkg::POS_RESET, 17'd0, 1'b0,
                                                   8'd0, 1'b0, 1'b0};
    localparam elc_pkg::t_result HALTED_STATUS = '{3'd1, 3'd0, 1'b0, 1'b1,
                                                   elc_pkg::POS_RESET, 17'd0, 1'b0,
                                                   8'd0, 1'b0, 1'b0};
    localparam elc_pkg::t_result VENT_STATUS   = '{3'd1, 3'd0, 1'b0, 1'b0,
                                                   elc_pkg::POS_RESET, 17'd0, 1'b0,
                                                   8'd0, 1'b1, 1'b0};

    typedef struct packed {
        logic [elc_pkg::TYPE_W-1:0]  kind;
        logic [elc_pkg::FLOOR_W-1:0] fl;
        logic [elc_pkg::DELTA_W-1:0] dt;
        logic                        typed;
        elc_pkg::t_result            want;
    } t_stim_row;

    // Directed walk: reset status, toggles, door cycle, dispatch, stop, lamp, no target
    localparam t_stim_row DIRECTED [26] = '{
        '{REQ_UNUSED,         3'd0, 16'd0,     1'b1, IDLE_STATUS},
        '{elc_pkg::REQ_STOP,  3'd0, 16'd0,     1'b1, HALTED_STATUS},
        '{elc_pkg::REQ_STOP,  3'd0, 16'd0,     1'b1, IDLE_STATUS},
        '{elc_pkg::REQ_VENT,  3'd0, 16'd0,     1'b1, VENT_STATUS},
        '{elc_pkg::REQ_CALL,  3'd1, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_TICK,  3'd0, 16'hFFFF,  1'b0, '0},
        '{elc_pkg::REQ_CLOSE, 3'd0, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_FLOOR, 3'd7, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_FLOOR, 3'd0, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_TICK,  3'd0, 16'd1000,  1'b0, '0},
        '{elc_pkg::REQ_TICK,  3'd0, 16'hFFFF,  1'b0, '0},
        '{elc_pkg::REQ_TICK,  3'd0, 16'hFFFF,  1'b0, '0},
        '{elc_pkg::REQ_TICK,  3'd0, 16'hFFFF,  1'b0, '0},
        '{elc_pkg::REQ_TICK,  3'd0, 16'hFFFF,  1'b0, '0},
        '{elc_pkg::REQ_FLOOR, 3'd3, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_TICK,  3'd0, 16'd500,   1'b0, '0},
        '{elc_pkg::REQ_STOP,  3'd0, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_TICK,  3'd0, 16'd1000,  1'b0, '0},
        '{elc_pkg::REQ_STOP,  3'd0, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_VENT,  3'd0, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_VENT,  3'd0, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_OPEN,  3'd0, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_TICK,  3'd0, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_TICK,  3'd0, 16'hFFFF,  1'b0, '0},
        '{elc_pkg::REQ_CALL,  3'd3, 16'd0,     1'b0, '0},
        '{elc_pkg::REQ_CLOSE, 3'd0, 16'd0,     1'b0, '0}
    };

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [elc_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [elc_pkg::TYPE_W-1:0]     s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [elc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [elc_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [elc_pkg::SPEED_W-1:0]    i_cfg_data    = '0;

    elevator_car_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Predicted controller state and register copies
    logic [elc_pkg::SPEED_W-1:0] car_speed_r;
    logic [elc_pkg::SPEED_W-1:0] door_rate_r;
    logic [elc_pkg::TIME_W-1:0]  open_time_r;
    logic [elc_pkg::FLOOR_W-1:0] at_floor;
    logic [elc_pkg::FLOOR_W-1:0] goal_floor;
    logic [elc_pkg::GOAL_W-1:0]  lamp_goal;
    logic [elc_pkg::POS_W-1:0]   car_pos;
    logic [elc_pkg::DOOR_W-1:0]  door_amt;
    logic [elc_pkg::TIME_W-1:0]  door_timer;
    logic [elc_pkg::FLOORS-1:0]  floor_calls;
    logic                        moving;
    logic                        halted;
    logic                        door_held;
    logic                        dispatch_pending;
    logic                        vent_on;
    logic                        vent_lamp;

    elc_pkg::t_result status_due [$];
    int      mismatches  = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    logic    hold_toggle = 1'b0;
    logic    hold_seen   = 1'b0;
    int      hold_left   = 0;
    int      quiet_cycles = 0;

    // Hold the doors open and arm the dispatch once they close
    function automatic void open_car_doors();
        door_held        = 1'b1;
        dispatch_pending = 1'b1;
        door_timer       = open_time_r;
    endfunction

    // Record a floor; go at once if the doors are shut, else start closing them
    function automatic void queue_floor(input logic [elc_pkg::FLOOR_W-1:0] fl,
                                        input logic light);
        floor_calls[fl] = 1'b1;
        if (!moving) begin
            if (door_amt == '0) begin
                goal_floor       = fl;
                lamp_goal        = {1'b0, fl};
                moving           = 1'b1;
                dispatch_pending = 1'b0;
                if (light && vent_on)
                    vent_lamp = 1'b1;
            end else begin
                door_held        = 1'b0;
                door_timer       = '0;
                dispatch_pending = 1'b1;
            end
        end
    endfunction

    // Advance the predicted state by one item and return the status it reports
    function automatic elc_pkg::t_result car_status_after(
        input logic [elc_pkg::TYPE_W-1:0]  kind,
        input logic [elc_pkg::FLOOR_W-1:0] fl,
        input logic [elc_pkg::DELTA_W-1:0] dt);
        logic             here;
        longint           span;
        longint           target;
        longint           travel_left;
        int               i;
        elc_pkg::t_result st;
        here = (fl == at_floor) && !moving;
        case (kind)
            elc_pkg::REQ_TICK: begin
                // Doors: open ones run the timer and widen, others narrow
                if (door_held) begin
                    door_timer = (dt >= door_timer) ? '0 : door_timer - dt;
                    if (door_amt < elc_pkg::DOOR_FULL) begin
                        span = longint'(door_amt) + longint'(door_rate_r) * longint'(dt);
                        door_amt = (span > longint'(elc_pkg::DOOR_FULL))
                                   ? elc_pkg::DOOR_FULL : span[elc_pkg::DOOR_W-1:0];
                    end
                    if (door_timer == '0)
                        door_held = 1'b0;
                end else begin
                    if (door_amt != '0) begin
                        span = longint'(door_rate_r) * longint'(dt);
                        door_amt = (span >= longint'(door_amt))
                                   ? '0 : door_amt - span[elc_pkg::DOOR_W-1:0];
                    end
                    // Doors shut: dispatch to the lowest floor waiting, if any
                    if (door_amt == '0 && dispatch_pending) begin
                        dispatch_pending = 1'b0;
                        goal_floor       = '0;
                        for (i = elc_pkg::FLOORS - 1; i >= 0; i--) begin
                            if (floor_calls[i]) begin
                                goal_floor = elc_pkg::FLOOR_W'(i);
                                moving     = 1'b1;
                            end
                        end
                    end
                end
                // Car travel, clamped at the target floor
                if (moving && !halted) begin
                    target      = longint'(goal_floor) * FLOOR_STEP;
                    span        = longint'(car_speed_r) * longint'(dt);
                    travel_left = (target >= longint'(car_pos))
                                  ? target - longint'(car_pos)
                                  : longint'(car_pos) - target;
                    if (travel_left <= span) begin
                        car_pos               = target[elc_pkg::POS_W-1:0];
                        at_floor              = goal_floor;
                        moving                = 1'b0;
                        floor_calls[at_floor] = 1'b0;
                        open_car_doors();
                        if (vent_lamp && {1'b0, at_floor} == lamp_goal)
                            vent_lamp = 1'b0;
                    end else if (target > longint'(car_pos)) begin
                        car_pos = car_pos + span[elc_pkg::POS_W-1:0];
                    end else begin
                        car_pos = car_pos - span[elc_pkg::POS_W-1:0];
                    end
                end
            end
            elc_pkg::REQ_FLOOR: begin
                if (!here)
                    queue_floor(fl, 1'b1);
            end
            elc_pkg::REQ_CALL: begin
                if (here) begin
                    if (!door_held)
                        open_car_doors();
                end else begin
                    queue_floor(fl, 1'b0);
                end
            end
            elc_pkg::REQ_OPEN: begin
                if (!moving)
                    open_car_doors();
            end
            elc_pkg::REQ_CLOSE: begin
                if (door_held || door_amt != '0) begin
                    door_held  = 1'b0;
                    door_timer = '0;
                end
            end
            elc_pkg::REQ_STOP: begin
                halted = ~halted;
            end
            elc_pkg::REQ_VENT: begin
                vent_on = ~vent_on;
                if (vent_on && moving)
                    vent_lamp = 1'b1;
            end
            default: begin
            end
        endcase
        st.current_floor    = at_floor;
        st.target_floor     = goal_floor;
        st.is_moving        = moving;
        st.is_stopped       = halted;
        st.car_position     = car_pos;
        st.door_amount      = door_amt;
        st.doors_open       = (door_amt > elc_pkg::DOOR_OPEN_MARK);
        st.pending_requests = floor_calls;
        st.ventilation_on   = vent_on;
        st.ventilation_lamp = vent_lamp;
        return st;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Offer one item after a random gap; predict its status once it transfers
    task automatic send_item(input logic [elc_pkg::TYPE_W-1:0]  kind,
                             input logic [elc_pkg::FLOOR_W-1:0] fl,
                             input logic [elc_pkg::DELTA_W-1:0] dt,
                             input logic                        typed,
                             input elc_pkg::t_result            want);
        elc_pkg::t_result due;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= elc_pkg::IN_DATA_W'({dt, fl});
        do @(posedge i_clk); while (!s_axis_tready);
        due = car_status_after(kind, fl, dt);
        status_due.push_back(typed ? want : due);
    endtask

    // Drop valid and wait for every predicted status to come back
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [elc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [elc_pkg::SPEED_W-1:0]   val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            elc_pkg::CFG_CAR_SPEED: car_speed_r = val;
            elc_pkg::CFG_DOOR_RATE: door_rate_r = val;
            elc_pkg::CFG_OPEN_TIME: open_time_r = val[elc_pkg::TIME_W-1:0];
            default: begin
            end
        endcase
    endtask

    // Status side: check each transfer, then pick next ready
    always @(posedge i_clk) begin
        elc_pkg::t_result got;
        elc_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.current_floor    = m_axis_tdata[2:0];
            got.target_floor     = m_axis_tdata[5:3];
            got.is_moving        = m_axis_tdata[6];
            got.is_stopped       = m_axis_tdata[7];
            got.car_position     = m_axis_tdata[26:8];
            got.door_amount      = m_axis_tdata[43:27];
            got.doors_open       = m_axis_tdata[44];
            got.pending_requests = m_axis_tdata[52:45];
            got.ventilation_on   = m_axis_tdata[53];
            got.ventilation_lamp = m_axis_tdata[54];
            if (status_due.size() == 0) begin
                mismatches++;
                $display("%0t: status expected none actual %h", $time, m_axis_tdata);
            end else begin
                want = status_due.pop_front();
                check_field("current_floor", want.current_floor, got.current_floor);
                check_field("target_floor", want.target_floor, got.target_floor);
                check_field("is_moving", want.is_moving, got.is_moving);
                check_field("is_stopped", want.is_stopped, got.is_stopped);
                check_field("car_position", want.car_position, got.car_position);
                check_field("door_amount", want.door_amount, got.door_amount);
                check_field("doors_open", want.doors_open, got.doors_open);
                check_field("pending_requests", want.pending_requests,
                            got.pending_requests);
                check_field("ventilation_on", want.ventilation_on, got.ventilation_on);
                check_field("ventilation_lamp", want.ventilation_lamp,
                            got.ventilation_lamp);
            end
        end
        if (hold_seen != hold_toggle) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int                          r;
        int                          ph;
        int                          roll;
        logic [elc_pkg::TYPE_W-1:0]  kind;
        logic [elc_pkg::FLOOR_W-1:0] fl;
        logic [elc_pkg::DELTA_W-1:0] dt;

        // Predicted state after reset
        car_speed_r      = elc_pkg::CAR_SPEED_RESET;
        door_rate_r      = elc_pkg::DOOR_RATE_RESET;
        open_time_r      = elc_pkg::OPEN_TIME_RESET;
        at_floor         = elc_pkg::FLOOR_RESET;
        goal_floor       = '0;
        lamp_goal        = elc_pkg::GOAL_NONE;
        car_pos          = elc_pkg::POS_RESET;
        door_amt         = '0;
        door_timer       = '0;
        floor_calls      = '0;
        moving           = 1'b0;
        halted           = 1'b0;
        door_held        = 1'b0;
        dispatch_pending = 1'b0;
        vent_on          = 1'b0;
        vent_lamp        = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table with light sender gaps and a slow receiver
        tx_idle_pct = 15;
        rx_idle_pct <= 82;
        foreach (DIRECTED[i])
            send_item(DIRECTED[i].kind, DIRECTED[i].fl, DIRECTED[i].dt, DIRECTED[i].typed,
                      DIRECTED[i].want);
        wait_for_drain();

        r = 0;
        for (ph = 0; ph < PHASES; ph++) begin
            // New register setting once the block is idle
            if (ph != 0) begin
                wait_for_drain();
                write_reg(elc_pkg::CFG_CAR_SPEED, CAR_SPEEDS[ph]);
                write_reg(elc_pkg::CFG_DOOR_RATE, DOOR_RATES[ph]);
                write_reg(elc_pkg::CFG_OPEN_TIME, elc_pkg::SPEED_W'(OPEN_TIMES[ph]));
                if (ph == 1)
                    write_reg(CFG_UNUSED, '1);
                i_cfg_valid <= 1'b0;
            end
            repeat (ITEMS_PER_PHASE) begin
                // Gap pattern: slow receiver, then slow sender, then none
                if (r < PHASES * ITEMS_PER_PHASE / 3) begin
                    tx_idle_pct = 15;
                    rx_idle_pct <= 82;
                end else if (r < 2 * PHASES * ITEMS_PER_PHASE / 3) begin
                    tx_idle_pct = 82;
                    rx_idle_pct <= 15;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
                if (r == PAUSE_AT)
                    wait_for_drain();
                if (r == HOLD_AT)
                    hold_toggle <= ~hold_toggle;

                roll = $urandom_range(0, 99);
                if (roll < 46)      kind = elc_pkg::REQ_TICK;
                else if (roll < 63) kind = elc_pkg::REQ_FLOOR;
                else if (roll < 77) kind = elc_pkg::REQ_CALL;
                else if (roll < 83) kind = elc_pkg::REQ_OPEN;
                else if (roll < 89) kind = elc_pkg::REQ_CLOSE;
                else if (roll < 91) kind = elc_pkg::REQ_STOP;
                else if (roll < 97) kind = elc_pkg::REQ_VENT;
                else                kind = REQ_UNUSED;
                fl = elc_pkg::FLOOR_W'($urandom_range(0, elc_pkg::FLOORS - 1));
                roll = $urandom_range(0, 9);
                if (roll < 6)      dt = elc_pkg::DELTA_W'($urandom_range(0, 40));
                else if (roll < 9) dt = elc_pkg::DELTA_W'($urandom_range(0, 3000));
                else               dt = elc_pkg::DELTA_W'($urandom_range(0, 65535));
                send_item(kind, fl, dt, 1'b0, '0);
                r++;
            end
        end

        wait_for_drain();
        if (mismatches == 0 && status_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
